// ===== sv/dpdd_pkg.sv =====
`default_nettype none

package dpdd_pkg;

    // Field widths
    localparam int POS_W     = 24;
    localparam int GAIN_W    = 16;
    localparam int SUM_W     = 40;
    localparam int FRAC_W    = 8;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = (POS_W > GAIN_W) ? POS_W : GAIN_W;
    localparam int CFG_IDX_W = 3;

    // Internal datapath widths
    localparam int ERR_W  = POS_W + 2;
    localparam int DIFF_W = ERR_W + 1;
    localparam int SUMX_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
    localparam int EP_W   = ERR_W + GAIN_W;
    localparam int DP_W   = DIFF_W + GAIN_W;
    localparam int SP_W   = SUM_W + GAIN_W;
    localparam int PMAX_W = (SP_W > DP_W) ? SP_W : DP_W;
    localparam int ACC_W  = PMAX_W + 2;
    localparam int PID_W  = ACC_W - FRAC_W;
    localparam int MIX_W  = PID_W + 1;

    // Saturation limits, widened to the intermediate sum widths
    localparam logic signed [SUMX_W-1:0] SUMX_MAX = SUMX_W'({(SUM_W-1){1'b1}});
    localparam logic signed [SUMX_W-1:0] SUMX_MIN = ~SUMX_MAX;
    localparam logic signed [MIX_W-1:0]  MIX_MAX  = MIX_W'({(OUT_W-1){1'b1}});
    localparam logic signed [MIX_W-1:0]  MIX_MIN  = ~MIX_MAX;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAT_KP      = 3'd0,
        REG_LAT_KI      = 3'd1,
        REG_LAT_KD      = 3'd2,
        REG_TRN_KP      = 3'd3,
        REG_TRN_KI      = 3'd4,
        REG_TRN_KD      = 3'd5,
        REG_TGT_DIST    = 3'd6,
        REG_TGT_TURN    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] left_position;
        logic signed [POS_W-1:0] right_position;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_power;
        logic signed [OUT_W-1:0] right_power;
    } out_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] lat_kp;
        logic signed [GAIN_W-1:0] lat_ki;
        logic signed [GAIN_W-1:0] lat_kd;
        logic signed [GAIN_W-1:0] trn_kp;
        logic signed [GAIN_W-1:0] trn_ki;
        logic signed [GAIN_W-1:0] trn_kd;
        logic signed [POS_W-1:0]  target_distance;
        logic signed [POS_W-1:0]  target_turn;
    } gains_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  lat_e;
        logic signed [DIFF_W-1:0] lat_d;
        logic signed [SUM_W-1:0]  lat_s;
        logic signed [ERR_W-1:0]  trn_e;
        logic signed [DIFF_W-1:0] trn_d;
        logic signed [SUM_W-1:0]  trn_s;
    } err_t;

    typedef struct packed {
        logic signed [EP_W-1:0] lat_p;
        logic signed [DP_W-1:0] lat_d;
        logic signed [SP_W-1:0] lat_i;
        logic signed [EP_W-1:0] trn_p;
        logic signed [DP_W-1:0] trn_d;
        logic signed [SP_W-1:0] trn_i;
    } prod_t;

endpackage

`default_nettype wire

// ===== sv/dpdd_error.sv =====
`default_nettype none

module dpdd_error (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  dpdd_pkg::in_t   in_item,
    input  dpdd_pkg::gains_t gains,
    output dpdd_pkg::err_t  err
);

    logic signed [dpdd_pkg::ERR_W-1:0]  lat_last_reg;
    logic signed [dpdd_pkg::ERR_W-1:0]  trn_last_reg;
    logic signed [dpdd_pkg::SUM_W-1:0]  lat_sum_reg;
    logic signed [dpdd_pkg::SUM_W-1:0]  trn_sum_reg;
    dpdd_pkg::err_t                     err_reg;
    dpdd_pkg::err_t                     err_next;

    logic signed [dpdd_pkg::POS_W:0]    pos_sum;
    logic signed [dpdd_pkg::POS_W:0]    pos_adj;
    logic signed [dpdd_pkg::POS_W:0]    pos_half;
    logic signed [dpdd_pkg::SUMX_W-1:0] lat_sumx;
    logic signed [dpdd_pkg::SUMX_W-1:0] trn_sumx;

    function automatic logic signed [dpdd_pkg::SUM_W-1:0] sat_sum(
        input logic signed [dpdd_pkg::SUMX_W-1:0] v
    );
        logic signed [dpdd_pkg::SUMX_W-1:0] c;
        c = v;
        if (v > dpdd_pkg::SUMX_MAX)
        begin
            c = dpdd_pkg::SUMX_MAX;
        end
        else if (v < dpdd_pkg::SUMX_MIN)
        begin
            c = dpdd_pkg::SUMX_MIN;
        end
        return c[dpdd_pkg::SUM_W-1:0];
    endfunction

    // Form both errors, their deltas and the clamped running sums
    always_comb
    begin
        pos_sum  = (dpdd_pkg::POS_W+1)'(in_item.left_position)
                 + (dpdd_pkg::POS_W+1)'(in_item.right_position);
        // halve toward zero: bias negative sums by one before the shift
        pos_adj  = pos_sum + (dpdd_pkg::POS_W+1)'(pos_sum[dpdd_pkg::POS_W]);
        pos_half = pos_adj >>> 1;

        err_next.lat_e = dpdd_pkg::ERR_W'(pos_half)
                       - dpdd_pkg::ERR_W'(gains.target_distance);
        err_next.trn_e = dpdd_pkg::ERR_W'(in_item.left_position)
                       - dpdd_pkg::ERR_W'(in_item.right_position)
                       - dpdd_pkg::ERR_W'(gains.target_turn);

        err_next.lat_d = dpdd_pkg::DIFF_W'(err_next.lat_e)
                       - dpdd_pkg::DIFF_W'(lat_last_reg);
        err_next.trn_d = dpdd_pkg::DIFF_W'(err_next.trn_e)
                       - dpdd_pkg::DIFF_W'(trn_last_reg);

        lat_sumx = dpdd_pkg::SUMX_W'(lat_sum_reg) + dpdd_pkg::SUMX_W'(err_next.lat_e);
        trn_sumx = dpdd_pkg::SUMX_W'(trn_sum_reg) + dpdd_pkg::SUMX_W'(err_next.trn_e);
        err_next.lat_s = sat_sum(lat_sumx);
        err_next.trn_s = sat_sum(trn_sumx);
    end

    // Advance loop state once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_last_reg <= '0;
            trn_last_reg <= '0;
            lat_sum_reg  <= '0;
            trn_sum_reg  <= '0;
        end
        else if (load)
        begin
            lat_last_reg <= err_next.lat_e;
            trn_last_reg <= err_next.trn_e;
            lat_sum_reg  <= err_next.lat_s;
            trn_sum_reg  <= err_next.trn_s;
        end
    end

    // Hold stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg <= err_next;
        end
    end

    assign err = err_reg;

endmodule

`default_nettype wire

// ===== sv/dpdd_mult.sv =====
`default_nettype none

module dpdd_mult (
    input  logic             clk,
    input  logic             load,
    input  dpdd_pkg::err_t   err,
    input  dpdd_pkg::gains_t gains,
    output dpdd_pkg::prod_t  prod
);

    dpdd_pkg::prod_t prod_reg;
    dpdd_pkg::prod_t prod_next;

    // Six independent gain products
    always_comb
    begin
        prod_next.lat_p = dpdd_pkg::EP_W'(err.lat_e) * dpdd_pkg::EP_W'(gains.lat_kp);
        prod_next.lat_d = dpdd_pkg::DP_W'(err.lat_d) * dpdd_pkg::DP_W'(gains.lat_kd);
        prod_next.lat_i = dpdd_pkg::SP_W'(err.lat_s) * dpdd_pkg::SP_W'(gains.lat_ki);
        prod_next.trn_p = dpdd_pkg::EP_W'(err.trn_e) * dpdd_pkg::EP_W'(gains.trn_kp);
        prod_next.trn_d = dpdd_pkg::DP_W'(err.trn_d) * dpdd_pkg::DP_W'(gains.trn_kd);
        prod_next.trn_i = dpdd_pkg::SP_W'(err.trn_s) * dpdd_pkg::SP_W'(gains.trn_ki);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== sv/dpdd_combine.sv =====
`default_nettype none

module dpdd_combine (
    input  logic            clk,
    input  logic            load,
    input  dpdd_pkg::prod_t prod,
    output dpdd_pkg::out_t  result
);

    dpdd_pkg::out_t                     result_reg;
    dpdd_pkg::out_t                     result_next;
    logic signed [dpdd_pkg::ACC_W-1:0]  lat_acc;
    logic signed [dpdd_pkg::ACC_W-1:0]  trn_acc;
    logic signed [dpdd_pkg::PID_W-1:0]  lat_pid;
    logic signed [dpdd_pkg::PID_W-1:0]  trn_pid;
    logic signed [dpdd_pkg::MIX_W-1:0]  left_mix;
    logic signed [dpdd_pkg::MIX_W-1:0]  right_mix;

    function automatic logic signed [dpdd_pkg::OUT_W-1:0] sat_out(
        input logic signed [dpdd_pkg::MIX_W-1:0] v
    );
        logic signed [dpdd_pkg::MIX_W-1:0] c;
        c = v;
        if (v > dpdd_pkg::MIX_MAX)
        begin
            c = dpdd_pkg::MIX_MAX;
        end
        else if (v < dpdd_pkg::MIX_MIN)
        begin
            c = dpdd_pkg::MIX_MIN;
        end
        return c[dpdd_pkg::OUT_W-1:0];
    endfunction

    // Sum terms, drop fraction bits (floor), mix and clamp
    always_comb
    begin
        lat_acc = dpdd_pkg::ACC_W'(prod.lat_p) + dpdd_pkg::ACC_W'(prod.lat_d)
                + dpdd_pkg::ACC_W'(prod.lat_i);
        trn_acc = dpdd_pkg::ACC_W'(prod.trn_p) + dpdd_pkg::ACC_W'(prod.trn_d)
                + dpdd_pkg::ACC_W'(prod.trn_i);
        lat_pid = lat_acc[dpdd_pkg::ACC_W-1:dpdd_pkg::FRAC_W];
        trn_pid = trn_acc[dpdd_pkg::ACC_W-1:dpdd_pkg::FRAC_W];

        left_mix  = dpdd_pkg::MIX_W'(lat_pid) - dpdd_pkg::MIX_W'(trn_pid);
        right_mix = dpdd_pkg::MIX_W'(lat_pid) + dpdd_pkg::MIX_W'(trn_pid);

        result_next.left_power  = sat_out(left_mix);
        result_next.right_power = sat_out(right_mix);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== sv/dual_pid_differential_drive.sv =====
// Path: in_reg, then the error, product and result registers, then out_data.
// Throughput: one request per cycle without stalls; each of the four stages loads
// whenever it is empty or its contents move on, so bubbles close while out_stall
// holds the output. Reset: rst_n clears all gains, targets, last errors, error
// sums and stage valid flags; requests are accepted once reset is released.
`default_nettype none

module dual_pid_differential_drive (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dpdd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dpdd_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  dpdd_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output dpdd_pkg::out_t                    out_data
);

    dpdd_pkg::gains_t gains_reg;
    dpdd_pkg::in_t    in_reg;
    dpdd_pkg::err_t   err;
    dpdd_pkg::prod_t  prod;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic load0, load1, load2, load3;
    logic move0, move1, move2, move3;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (dpdd_pkg::cfg_reg_t'(cfg_index))
                dpdd_pkg::REG_LAT_KP:
                    gains_reg.lat_kp <= cfg_data[dpdd_pkg::GAIN_W-1:0];
                dpdd_pkg::REG_LAT_KI:
                    gains_reg.lat_ki <= cfg_data[dpdd_pkg::GAIN_W-1:0];
                dpdd_pkg::REG_LAT_KD:
                    gains_reg.lat_kd <= cfg_data[dpdd_pkg::GAIN_W-1:0];
                dpdd_pkg::REG_TRN_KP:
                    gains_reg.trn_kp <= cfg_data[dpdd_pkg::GAIN_W-1:0];
                dpdd_pkg::REG_TRN_KI:
                    gains_reg.trn_ki <= cfg_data[dpdd_pkg::GAIN_W-1:0];
                dpdd_pkg::REG_TRN_KD:
                    gains_reg.trn_kd <= cfg_data[dpdd_pkg::GAIN_W-1:0];
                dpdd_pkg::REG_TGT_DIST:
                    gains_reg.target_distance <= cfg_data[dpdd_pkg::POS_W-1:0];
                dpdd_pkg::REG_TGT_TURN:
                    gains_reg.target_turn <= cfg_data[dpdd_pkg::POS_W-1:0];
                default:
                    gains_reg <= gains_reg;
            endcase
        end
    end

    // Stage handshake: a stage loads when empty or when its contents move on
    always_comb
    begin
        move3 = v3_reg && !out_stall;
        load3 = !v3_reg || move3;
        move2 = v2_reg && load3;
        load2 = !v2_reg || move2;
        move1 = v1_reg && load2;
        load1 = !v1_reg || move1;
        move0 = v0_reg && load1;
        load0 = !v0_reg || move0;
    end

    assign in_stall  = !load0;
    assign out_valid = v3_reg;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (load0)
            begin
                v0_reg <= in_valid;
            end
            if (load1)
            begin
                v1_reg <= move0;
            end
            if (load2)
            begin
                v2_reg <= move1;
            end
            if (load3)
            begin
                v3_reg <= move2;
            end
        end
    end

    // Capture input request
    always_ff @(posedge clk)
    begin
        if (load0 && in_valid)
        begin
            in_reg <= in_data;
        end
    end

    dpdd_error u_error (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (move0),
        .in_item (in_reg),
        .gains   (gains_reg),
        .err     (err)
    );

    dpdd_mult u_mult (
        .clk   (clk),
        .load  (move1),
        .err   (err),
        .gains (gains_reg),
        .prod  (prod)
    );

    dpdd_combine u_combine (
        .clk    (clk),
        .load   (move2),
        .prod   (prod),
        .result (out_data)
    );

endmodule

`default_nettype wire

// ===== sv/dpdd_checker.sv =====
`default_nettype none

module dpdd_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  logic           out_valid,
    input  logic           out_stall,
    input  dpdd_pkg::out_t out_data
);

    // Hold a stalled result
    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("out_data changed while stalled");

    // The pipeline never pushes back unless the output register is blocked
    a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || !out_stall |-> !in_stall)
        else $error("in_stall raised with output free");

    // An accepted request reaches out_valid while out_stall stays low behind it
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind dual_pid_differential_drive dpdd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
